@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands shared by the checker files.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/yhscb_pkg.sv @@
// ----------------------------------------------------------------------------
// yhscb_pkg
// Types, register codes and constants for the YUV proc-amp pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package yhscb_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 14;

    typedef logic [7:0] pix_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_HUE_COSINE  = 3'd0,
        REG_HUE_SINE    = 3'd1,
        REG_SAT_GAIN    = 3'd2,
        REG_CON_GAIN    = 3'd3,
        REG_BRIGHTNESS  = 3'd4,
        REG_PLANAR_MODE = 3'd5
    } cfg_reg_t;

    localparam logic signed [13:0] HUE_COSINE_RST = 14'sd4096;
    localparam logic signed [13:0] HUE_SINE_RST   = 14'sd0;
    localparam logic [10:0]        GAIN_UNITY     = 11'd512;

    localparam logic signed [8:0] LUMA_BLACK = 9'sd16;
    localparam logic signed [8:0] CHROMA_MID = 9'sd128;

    localparam pix_t PACKED_MIN        = 8'd0;
    localparam pix_t PACKED_MAX        = 8'd255;
    localparam pix_t PLANAR_LUMA_MIN   = 8'd15;
    localparam pix_t PLANAR_LUMA_MAX   = 8'd235;
    localparam pix_t PLANAR_CHROMA_MIN = 8'd16;
    localparam pix_t PLANAR_CHROMA_MAX = 8'd240;

    // per-stage load enables, shared between the top and the luma lanes
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
    } stage_en_t;

    function automatic pix_t clamp8(input logic signed [15:0] x,
                                    input pix_t lo, input pix_t hi);
        logic signed [15:0] l;
        logic signed [15:0] h;
        l = $signed({8'd0, lo});
        h = $signed({8'd0, hi});
        if (x < l)
            return lo;
        else if (x > h)
            return hi;
        else
            return x[7:0];
    endfunction

endpackage

@@ rtl/core/yuv_hue_sat_contrast_bright.sv @@
// ----------------------------------------------------------------------------
// yuv_hue_sat_contrast_bright
// YUV 4:2:2 proc-amp: contrast, brightness, hue rotation and saturation.
// ----------------------------------------------------------------------------
// One word (two luma samples and a Cb/Cr pair) is taken per clock while
// in_ready is high. It passes four register stages (products, hue sum,
// saturation product, clamp) before it can leave. Each stage holds its word
// only while the stage after it is full and stalled, so bubbles are squeezed
// out; a waiting output word holds off the input only once all four stages
// are full.
// Configuration writes take effect at once and are meant for idle periods.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module yuv_hue_sat_contrast_bright (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_wen,
    input  logic [yhscb_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [yhscb_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  yhscb_pkg::pix_t                      luma_first,
    input  yhscb_pkg::pix_t                      luma_second,
    input  yhscb_pkg::pix_t                      chroma_blue,
    input  yhscb_pkg::pix_t                      chroma_red,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output yhscb_pkg::pix_t                      luma_first_out,
    output yhscb_pkg::pix_t                      luma_second_out,
    output yhscb_pkg::pix_t                      chroma_blue_out,
    output yhscb_pkg::pix_t                      chroma_red_out
);
    import yhscb_pkg::*;

    // configuration registers
    logic signed [13:0] hue_cos_reg, hue_sin_reg;
    logic [10:0]        sat_gain_reg, con_gain_reg;
    logic signed [8:0]  bright_reg;
    logic               planar_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hue_cos_reg  <= HUE_COSINE_RST;
            hue_sin_reg  <= HUE_SINE_RST;
            sat_gain_reg <= GAIN_UNITY;
            con_gain_reg <= GAIN_UNITY;
            bright_reg   <= '0;
            planar_reg   <= 1'b0;
        end
        else if (cfg_wen)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_HUE_COSINE:  hue_cos_reg  <= $signed(cfg_data[13:0]);
                REG_HUE_SINE:    hue_sin_reg  <= $signed(cfg_data[13:0]);
                REG_SAT_GAIN:    sat_gain_reg <= cfg_data[10:0];
                REG_CON_GAIN:    con_gain_reg <= cfg_data[10:0];
                REG_BRIGHTNESS:  bright_reg   <= $signed(cfg_data[8:0]);
                REG_PLANAR_MODE: planar_reg   <= cfg_data[0];
                default:         ;
            endcase
        end
    end

    // valid chain and per-stage ready
    logic      v1_reg, v2_reg, v3_reg, v4_reg;
    logic      rdy1, rdy2, rdy3, rdy4;
    stage_en_t en;

    always_comb
    begin
        rdy4  = !v4_reg || out_ready;
        rdy3  = !v3_reg || rdy4;
        rdy2  = !v2_reg || rdy3;
        rdy1  = !v1_reg || rdy2;
        en.s1 = rdy1;
        en.s2 = rdy2;
        en.s3 = rdy3;
        en.s4 = rdy4;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
                v1_reg <= in_valid;
            if (rdy2)
                v2_reg <= v1_reg;
            if (rdy3)
                v3_reg <= v2_reg;
            if (rdy4)
                v4_reg <= v3_reg;
        end
    end

    assign in_ready  = rdy1;
    assign out_valid = v4_reg;

    // luma lanes
    yhscb_luma u_luma_first (
        .clk               (clk),
        .en                (en),
        .luma              (luma_first),
        .contrast_gain     (con_gain_reg),
        .brightness_offset (bright_reg),
        .planar_mode       (planar_reg),
        .luma_out          (luma_first_out)
    );

    yhscb_luma u_luma_second (
        .clk               (clk),
        .en                (en),
        .luma              (luma_second),
        .contrast_gain     (con_gain_reg),
        .brightness_offset (bright_reg),
        .planar_mode       (planar_reg),
        .luma_out          (luma_second_out)
    );

    // chroma path
    logic signed [8:0]  u_cen, v_cen;
    logic signed [22:0] ucos_reg, vsin_reg, vcos_reg, usin_reg;
    logic signed [23:0] ru_sum, rv_sum;
    logic signed [11:0] ru_reg, rv_reg;
    logic signed [23:0] us_reg, vs_reg;
    logic signed [15:0] cb_t, cr_t;
    pix_t               cb_next, cr_next, cb_reg, cr_reg;
    pix_t               c_lo, c_hi;

    always_comb
    begin
        u_cen  = $signed({1'b0, chroma_blue}) - CHROMA_MID;
        v_cen  = $signed({1'b0, chroma_red}) - CHROMA_MID;
        ru_sum = 24'(ucos_reg) + 24'(vsin_reg);
        rv_sum = 24'(vcos_reg) - 24'(usin_reg);
        cb_t   = 16'(us_reg >>> 9) + 16'(CHROMA_MID);
        cr_t   = 16'(vs_reg >>> 9) + 16'(CHROMA_MID);
        c_lo   = planar_reg ? PLANAR_CHROMA_MIN : PACKED_MIN;
        c_hi   = planar_reg ? PLANAR_CHROMA_MAX : PACKED_MAX;
        cb_next = clamp8(cb_t, c_lo, c_hi);
        cr_next = clamp8(cr_t, c_lo, c_hi);
    end

    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            ucos_reg <= u_cen * hue_cos_reg;
            vsin_reg <= v_cen * hue_sin_reg;
            vcos_reg <= v_cen * hue_cos_reg;
            usin_reg <= u_cen * hue_sin_reg;
        end
        if (en.s2)
        begin
            ru_reg <= 12'(ru_sum >>> 12);
            rv_reg <= 12'(rv_sum >>> 12);
        end
        if (en.s3)
        begin
            us_reg <= ru_reg * $signed({1'b0, sat_gain_reg});
            vs_reg <= rv_reg * $signed({1'b0, sat_gain_reg});
        end
        if (en.s4)
        begin
            cb_reg <= cb_next;
            cr_reg <= cr_next;
        end
    end

    assign chroma_blue_out = cb_reg;
    assign chroma_red_out  = cr_reg;

endmodule

@@ rtl/core/yhscb_luma.sv @@
// ----------------------------------------------------------------------------
// yhscb_luma
// One luma lane: contrast about black, brightness offset, clamp. Four stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module yhscb_luma (
    input  logic                 clk,
    input  yhscb_pkg::stage_en_t en,
    input  yhscb_pkg::pix_t      luma,
    input  logic [10:0]          contrast_gain,
    input  logic signed [8:0]    brightness_offset,
    input  logic                 planar_mode,
    output yhscb_pkg::pix_t      luma_out
);
    import yhscb_pkg::*;

    logic signed [8:0]  centred;
    logic signed [20:0] prod_next, prod_reg;
    logic signed [12:0] sum_next, sum_reg, hold_reg;
    pix_t               out_next, out_reg;

    always_comb
    begin
        centred   = $signed({1'b0, luma}) - LUMA_BLACK;
        prod_next = centred * $signed({1'b0, contrast_gain});
        sum_next  = 13'(prod_reg >>> 9) + 13'(brightness_offset) + 13'(LUMA_BLACK);
        if (planar_mode)
            out_next = clamp8(16'(hold_reg), PLANAR_LUMA_MIN, PLANAR_LUMA_MAX);
        else
            out_next = clamp8(16'(hold_reg), PACKED_MIN, PACKED_MAX);
    end

    always_ff @(posedge clk)
    begin
        if (en.s1)
            prod_reg <= prod_next;
        if (en.s2)
            sum_reg <= sum_next;
        if (en.s3)
            hold_reg <= sum_reg;
        if (en.s4)
            out_reg <= out_next;
    end

    assign luma_out = out_reg;

endmodule

@@ rtl/core/yhscb_checker.sv @@
// ----------------------------------------------------------------------------
// yhscb_checker
// Port-level checks for the proc-amp: flow control and planar output range.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module yhscb_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             cfg_wen,
    input logic [yhscb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input logic [yhscb_pkg::CFG_DATA_W-1:0] cfg_data,
    input logic                             in_ready,
    input logic                             out_valid,
    input logic                             out_ready,
    input yhscb_pkg::pix_t                  luma_first_out,
    input yhscb_pkg::pix_t                  luma_second_out,
    input yhscb_pkg::pix_t                  chroma_blue_out,
    input yhscb_pkg::pix_t                  chroma_red_out
);
    import yhscb_pkg::*;

    // shadow of the planar mode bit
    logic planar_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            planar_reg <= 1'b0;
        else if (cfg_wen && cfg_index == REG_PLANAR_MODE)
            planar_reg <= cfg_data[0];
    end

    logic        luma_ok, chroma_ok;
    logic        out_free, out_stall, planar_out;
    logic [31:0] out_word;

    always_comb
    begin
        luma_ok = luma_first_out >= PLANAR_LUMA_MIN && luma_first_out <= PLANAR_LUMA_MAX
               && luma_second_out >= PLANAR_LUMA_MIN && luma_second_out <= PLANAR_LUMA_MAX;
        chroma_ok = chroma_blue_out >= PLANAR_CHROMA_MIN
                 && chroma_blue_out <= PLANAR_CHROMA_MAX
                 && chroma_red_out >= PLANAR_CHROMA_MIN
                 && chroma_red_out <= PLANAR_CHROMA_MAX;
        out_free   = !out_valid || out_ready;
        out_stall  = out_valid && !out_ready;
        planar_out = out_valid && planar_reg;
        out_word   = {luma_first_out, luma_second_out, chroma_blue_out, chroma_red_out};
    end

    // an empty or draining output stage frees the whole pipe
    `ASSERT_IMPLY(a_ready_flow, clk, rst_n, out_free, in_ready, "input stalled, output free")

    `ASSERT_NEXT(a_valid_hold, clk, rst_n, out_stall, out_valid, "valid dropped while stalled")

    `ASSERT_NEXT(a_word_hold, clk, rst_n, out_stall, $stable(out_word), "stalled word changed")

    `ASSERT_IMPLY(a_planar_range, clk, rst_n, planar_out, luma_ok && chroma_ok, "bad planar output")

endmodule

bind yuv_hue_sat_contrast_bright yhscb_checker u_yhscb_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wen         (cfg_wen),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_ready        (in_ready),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .luma_first_out  (luma_first_out),
    .luma_second_out (luma_second_out),
    .chroma_blue_out (chroma_blue_out),
    .chroma_red_out  (chroma_red_out)
);

@@ verif/yuv_hue_sat_contrast_bright_tb.sv @@
// ----------------------------------------------------------------------------
// yuv_hue_sat_contrast_bright_tb
// Self-checking bench for the YUV proc-amp pipeline.
// ----------------------------------------------------------------------------
// A scoreboard class predicts each accepted word from its own copy of the
// six registers and checks results in order. A short directed part hits
// the clamp limits, register extremes, raw bit patterns and unused register
// indexes. Random phases follow, each with new register settings and, in most
// phases, with random gaps on both handshakes. One phase stalls the output for a long
// stretch so that the pipeline backs up.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module yuv_hue_sat_contrast_bright_tb;

    import yhscb_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RAND_PHASES  = 8;
    localparam int PHASE_WORDS  = 62;
    localparam int LONG_HOLD    = 300;
    localparam int DRAIN_CYCLES = 20;

    // indexes past the register list; writes there must be ignored
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    typedef struct packed {
        pix_t y0;
        pix_t y1;
        pix_t cb;
        pix_t cr;
    } group_t;

    typedef struct {
        logic [CFG_DATA_W-1:0] hue_cos;
        logic [CFG_DATA_W-1:0] hue_sin;
        logic [CFG_DATA_W-1:0] sat;
        logic [CFG_DATA_W-1:0] con;
        logic [CFG_DATA_W-1:0] bright;
        logic [CFG_DATA_W-1:0] planar;
    } settings_t;

    class procamp_scoreboard;
        longint hue_cos;
        longint hue_sin;
        longint sat_gain;
        longint con_gain;
        longint bright;
        bit     planar;
        group_t due_groups[$];
        int     errors;
        int     reported;

        function new();
            hue_cos  = HUE_COSINE_RST;
            hue_sin  = HUE_SINE_RST;
            sat_gain = GAIN_UNITY;
            con_gain = GAIN_UNITY;
            bright   = 0;
            planar   = 1'b0;
            errors   = 0;
            reported = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
            case (idx)
                REG_HUE_COSINE:  hue_cos  = $signed(d[13:0]);
                REG_HUE_SINE:    hue_sin  = $signed(d[13:0]);
                REG_SAT_GAIN:    sat_gain = d[10:0];
                REG_CON_GAIN:    con_gain = d[10:0];
                REG_BRIGHTNESS:  bright   = $signed(d[8:0]);
                REG_PLANAR_MODE: planar   = d[0];
                default: ;
            endcase
        endfunction

        function pix_t clip(longint x, longint lo, longint hi);
            if (x < lo)
                x = lo;
            if (x > hi)
                x = hi;
            return x[7:0];
        endfunction

        function pix_t luma_adj(pix_t y);
            longint t;
            t = y;
            t = (((t - LUMA_BLACK) * con_gain) >>> 9) + bright + LUMA_BLACK;
            if (planar)
                return clip(t, PLANAR_LUMA_MIN, PLANAR_LUMA_MAX);
            return clip(t, PACKED_MIN, PACKED_MAX);
        endfunction

        function pix_t chroma_adj(longint c);
            longint t;
            t = ((c * sat_gain) >>> 9) + CHROMA_MID;
            if (planar)
                return clip(t, PLANAR_CHROMA_MIN, PLANAR_CHROMA_MAX);
            return clip(t, PACKED_MIN, PACKED_MAX);
        endfunction

        function group_t procamp(group_t g);
            group_t r;
            longint u;
            longint v;
            longint ru;
            longint rv;
            u = g.cb;
            v = g.cr;
            u = u - CHROMA_MID;
            v = v - CHROMA_MID;
            // hue rotation, Q12 sum floored
            ru = (u * hue_cos + v * hue_sin) >>> 12;
            rv = (v * hue_cos - u * hue_sin) >>> 12;
            r.y0 = luma_adj(g.y0);
            r.y1 = luma_adj(g.y1);
            r.cb = chroma_adj(ru);
            r.cr = chroma_adj(rv);
            return r;
        endfunction

        function void note_input(group_t g);
            due_groups.push_back(procamp(g));
        endfunction

        function int pending();
            return due_groups.size();
        endfunction

        function void check_result(group_t got);
            group_t want;
            if (due_groups.size() == 0) begin
                errors++;
                if (reported < 10) begin
                    reported++;
                    $display("ERROR: unexpected output word %h", got);
                end
                return;
            end
            want = due_groups.pop_front();
            if (got.y0 !== want.y0 || got.y1 !== want.y1 ||
                got.cb !== want.cb || got.cr !== want.cr) begin
                errors++;
                if (reported < 10) begin
                    reported++;
                    $display("ERROR: y0/y1/cb/cr expected %h %h %h %h, got %h %h %h %h",
                             want.y0, want.y1, want.cb, want.cr,
                             got.y0, got.y1, got.cb, got.cr);
                end
            end
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_wen;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_ready;
    pix_t                  luma_first;
    pix_t                  luma_second;
    pix_t                  chroma_blue;
    pix_t                  chroma_red;
    logic                  out_valid;
    logic                  out_ready;
    pix_t                  luma_first_out;
    pix_t                  luma_second_out;
    pix_t                  chroma_blue_out;
    pix_t                  chroma_red_out;

    procamp_scoreboard sb = new();
    bit idle_on  = 1'b1;
    int hold_req = 0;
    int cycles   = 0;

    yuv_hue_sat_contrast_bright dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_wen         (cfg_wen),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .luma_first      (luma_first),
        .luma_second     (luma_second),
        .chroma_blue     (chroma_blue),
        .chroma_red      (chroma_red),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .luma_first_out  (luma_first_out),
        .luma_second_out (luma_second_out),
        .chroma_blue_out (chroma_blue_out),
        .chroma_red_out  (chroma_red_out)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic group_t random_group();
        group_t g;
        int     r;
        r = $urandom_range(0, 99);
        g = group_t'($urandom);
        if (r < 15) begin
            // near black level and neutral chroma
            g.y0 = 8'($urandom_range(0, 32));
            g.y1 = 8'($urandom_range(0, 32));
            g.cb = 8'($urandom_range(120, 136));
            g.cr = 8'($urandom_range(120, 136));
        end else if (r < 25) begin
            g.y0 = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            g.y1 = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            g.cb = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            g.cr = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        end
        return g;
    endfunction

    function automatic settings_t random_settings(bit raw);
        settings_t s;
        real       ang;
        int        c;
        int        sn;
        if (raw) begin
            // any bit pattern, including bits above each register's width
            s.hue_cos = 14'($urandom_range(0, 16383));
            s.hue_sin = 14'($urandom_range(0, 16383));
            s.sat     = 14'($urandom_range(0, 16383));
            s.con     = 14'($urandom_range(0, 16383));
            s.bright  = 14'($urandom_range(0, 16383));
            s.planar  = 14'($urandom_range(0, 16383));
            return s;
        end
        if ($urandom_range(0, 1)) begin
            ang = $urandom_range(0, 359) * 3.14159265 / 180.0;
            c   = $rtoi(4096.0 * $cos(ang));
            sn  = $rtoi(4096.0 * $sin(ang));
        end else begin
            c  = $urandom_range(0, 8192) - 4096;
            sn = $urandom_range(0, 8192) - 4096;
        end
        s.hue_cos = c[13:0];
        s.hue_sin = sn[13:0];
        s.sat     = 14'($urandom_range(0, 1024));
        s.con     = 14'($urandom_range(0, 1024));
        c         = $urandom_range(0, 510) - 255;
        s.bright  = c[13:0];
        s.planar  = 14'($urandom_range(0, 1));
        return s;
    endfunction

    task automatic wait_empty();
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic put_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
        cfg_wen   <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(posedge clk);
        sb.write_reg(idx, d);
    endtask

    // only called with the pipeline empty
    task automatic load_settings(settings_t s);
        wait_empty();
        put_reg(REG_HUE_COSINE, s.hue_cos);
        put_reg(REG_HUE_SINE, s.hue_sin);
        put_reg(REG_SAT_GAIN, s.sat);
        put_reg(REG_CON_GAIN, s.con);
        put_reg(REG_BRIGHTNESS, s.bright);
        put_reg(REG_PLANAR_MODE, s.planar);
        put_reg(REG_SPARE_LO, 14'($urandom_range(0, 16383)));
        put_reg(REG_SPARE_HI, 14'($urandom_range(0, 16383)));
        cfg_wen <= 1'b0;
    endtask

    task automatic send_group(group_t g);
        int gap;
        in_valid    <= 1'b1;
        luma_first  <= g.y0;
        luma_second <= g.y1;
        chroma_blue <= g.cb;
        chroma_red  <= g.cr;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_input(g);
        gap = idle_on ? pick_gap() : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // result side: random stalls plus an on-demand long hold-off
    initial
    begin : result_sink
        int     stall_left;
        int     run_left;
        group_t got;
        stall_left = 0;
        run_left   = 0;
        out_ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (out_valid && out_ready) begin
                got.y0 = luma_first_out;
                got.y1 = luma_second_out;
                got.cb = chroma_blue_out;
                got.cr = chroma_red_out;
                sb.check_result(got);
            end
            if (hold_req > 0) begin
                stall_left = hold_req;
                hold_req   = 0;
            end
            if (stall_left > 0) begin
                stall_left--;
                out_ready <= 1'b0;
            end else if (run_left > 0 || !idle_on) begin
                if (run_left > 0)
                    run_left--;
                out_ready <= 1'b1;
            end else begin
                run_left   = $urandom_range(0, 24);
                stall_left = pick_gap();
                out_ready <= (stall_left == 0);
                if (stall_left > 0)
                    stall_left--;
            end
        end
    end

    initial
    begin : stimulus
        settings_t s;
        rst_n       <= 1'b0;
        cfg_wen     <= 1'b0;
        cfg_index   <= REG_HUE_COSINE;
        cfg_data    <= '0;
        in_valid    <= 1'b0;
        luma_first  <= '0;
        luma_second <= '0;
        chroma_blue <= '0;
        chroma_red  <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: unity gains, no rotation, packed clamp
        send_group('{8'd0, 8'd255, 8'd0, 8'd255});
        send_group('{8'd255, 8'd0, 8'd255, 8'd0});
        send_group('{8'd16, 8'd16, 8'd128, 8'd128});
        send_group('{8'd15, 8'd235, 8'd16, 8'd240});
        send_group('{8'd128, 8'd127, 8'd127, 8'd129});
        in_valid <= 1'b0;

        // quarter-turn hue, double gains, full brightness, planar clamp
        s = '{14'd0, 14'd4096, 14'd1024, 14'd1024, 14'd255, 14'd1};
        load_settings(s);
        send_group('{8'd0, 8'd255, 8'd0, 8'd255});
        send_group('{8'd16, 8'd128, 8'd255, 8'd0});
        send_group('{8'd235, 8'd15, 8'd1, 8'd254});
        send_group('{8'd100, 8'd200, 8'd128, 8'd128});
        in_valid <= 1'b0;

        // most negative / largest raw register patterns
        s = '{14'h2000, 14'h1FFF, 14'h07FF, 14'h07FF, 14'h0100, 14'd0};
        load_settings(s);
        send_group('{8'd0, 8'd255, 8'd0, 8'd255});
        send_group('{8'd255, 8'd0, 8'd255, 8'd0});
        send_group('{8'd16, 8'd17, 8'd129, 8'd127});
        send_group('{8'd200, 8'd50, 8'd60, 8'd190});
        in_valid <= 1'b0;

        // non-unit rotation pair, zero gains, brightness -255, planar
        s = '{14'h3000, 14'h3000, 14'd0, 14'd0, 14'h3F01, 14'd1};
        load_settings(s);
        send_group('{8'd0, 8'd255, 8'd0, 8'd255});
        send_group('{8'd255, 8'd255, 8'd255, 8'd255});
        send_group('{8'd16, 8'd16, 8'd128, 8'd128});
        in_valid <= 1'b0;

        s = '{14'd4096, 14'd0, 14'd512, 14'd0, 14'd255, 14'd0};
        load_settings(s);
        send_group('{8'd0, 8'd255, 8'd0, 8'd0});
        send_group('{8'd16, 8'd200, 8'd255, 8'd255});
        in_valid <= 1'b0;

        for (int p = 0; p < RAND_PHASES; p++) begin
            load_settings(random_settings(p == 4 || p == 7));
            // phase 2: output held off while words keep coming in
            idle_on = (p != 2 && p != 6);
            if (p == 2)
                hold_req = LONG_HOLD;
            for (int i = 0; i < PHASE_WORDS; i++)
                send_group(random_group());
            in_valid <= 1'b0;
            wait_empty();
        end

        idle_on = 1'b1;
        wait_empty();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
